// File: hdl/mae_pkg.sv
// shared types and constants for the mps amplitude evaluator
// no dependencies

package mae_pkg;

  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_QUERY = 1'b1
  } kind_t;

  localparam int BASIS_WIDTH = 16;
  localparam int CFG_BITS    = 5;
  localparam int SITE_BITS   = 4;
  localparam int BOND_BITS   = 3;

endpackage

// File: hdl/mae_ram.sv
// generic single-port-write, single-read ram with registered read data
// no dependencies

module mae_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule

// File: hdl/mae_cell.sv
// one bond-column cell: complex multiply-accumulate over rows of one column
// depends on nothing but its ports

module mae_cell #(
  parameter int VALUE_BITS = 18,
  parameter int FRAC_BITS  = 15
) (
  input  logic                         clk,
  input  logic                         clear,
  input  logic                         mac_en,
  input  logic signed [VALUE_BITS-1:0] v_re,
  input  logic signed [VALUE_BITS-1:0] v_im,
  input  logic signed [VALUE_BITS-1:0] t_re,
  input  logic signed [VALUE_BITS-1:0] t_im,
  input  logic                         load,
  input  logic signed [VALUE_BITS-1:0] shift_in_re,
  input  logic signed [VALUE_BITS-1:0] shift_in_im,
  input  logic                         shift_en,
  output logic signed [VALUE_BITS-1:0] out_re,
  output logic signed [VALUE_BITS-1:0] out_im
);

  localparam int PW = 2 * VALUE_BITS;
  localparam int AW = PW + 8;

  logic signed [PW-1:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r;
  logic                 pv_r;
  logic signed [AW-1:0] acc_re_r, acc_im_r;
  logic signed [VALUE_BITS-1:0] hold_re_r, hold_im_r;

  function automatic logic signed [VALUE_BITS-1:0] rnd_sat(input logic signed [AW-1:0] a);
    logic signed [AW-1:0] y;
    logic signed [AW-1:0] q;
    logic signed [AW-1:0] hi;
    logic signed [AW-1:0] lo;
    hi = (AW'(1) <<< (VALUE_BITS - 1)) - AW'(1);
    lo = -(AW'(1) <<< (VALUE_BITS - 1));
    y  = a + (AW'(1) <<< (FRAC_BITS - 1));
    q  = y >>> FRAC_BITS;
    if (q > hi) q = hi;
    if (q < lo) q = lo;
    return q[VALUE_BITS-1:0];
  endfunction

  // product stage, then accumulate
  always_ff @(posedge clk) begin
    p_rr_r <= PW'(v_re) * PW'(t_re);
    p_ii_r <= PW'(v_im) * PW'(t_im);
    p_ri_r <= PW'(v_re) * PW'(t_im);
    p_ir_r <= PW'(v_im) * PW'(t_re);
    pv_r   <= mac_en;
    if (clear) begin
      acc_re_r <= '0;
      acc_im_r <= '0;
    end else if (pv_r) begin
      acc_re_r <= acc_re_r + AW'(p_rr_r) - AW'(p_ii_r);
      acc_im_r <= acc_im_r + AW'(p_ri_r) + AW'(p_ir_r);
    end
    // rounded result loads, then shifts along the row of cells
    if (load) begin
      hold_re_r <= rnd_sat(acc_re_r);
      hold_im_r <= rnd_sat(acc_im_r);
    end else if (shift_en) begin
      hold_re_r <= shift_in_re;
      hold_im_r <= shift_in_im;
    end
  end

  assign out_re = hold_re_r;
  assign out_im = hold_im_r;

endmodule

// File: hdl/mps_amplitude_evaluator.sv
// top level of the mps amplitude evaluator: store, sequencer and cell row
// depends on mae_pkg, mae_ram and mae_cell

// A tensor write is a read-modify-write of one store row: the row is fetched,
// the entry merged in and the row written back, so the input is held off
// until the write-back is done. A query walks site_count sites, at most
// MAX_SITES; at each site the row of MAX_BOND cells, one per bond column, takes
// one vector element per cycle while the store streams one column entry to
// every cell, then the new vector shifts back through the cell row. A finished
// amplitude waits in the output register, so the next item can be taken while
// it is not yet read. After reset a clearing pass zeroes all MAX_SITES * 2 *
// MAX_BOND store rows, one row of MAX_BOND entries a cycle, while no item is
// accepted.
module mps_amplitude_evaluator import mae_pkg::*; #(
  parameter int MAX_SITES  = 16,
  parameter int MAX_BOND   = 8,
  parameter int VALUE_BITS = 18
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_kind,
  input  logic [SITE_BITS-1:0]         in_site,
  input  logic                         in_phys_bit,
  input  logic [BOND_BITS-1:0]         in_row,
  input  logic [BOND_BITS-1:0]         in_column,
  input  logic signed [VALUE_BITS-1:0] in_entry_re,
  input  logic signed [VALUE_BITS-1:0] in_entry_im,
  input  logic [BASIS_WIDTH-1:0]       in_basis_bits,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [VALUE_BITS-1:0] out_amp_re,
  output logic signed [VALUE_BITS-1:0] out_amp_im,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_BITS-1:0]          cfg_site_count
);

  localparam int FRAC_BITS = VALUE_BITS - 3;
  localparam int SB  = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
  localparam int BB  = (MAX_BOND > 1) ? $clog2(MAX_BOND) : 1;
  localparam int RD  = MAX_SITES * 2 * MAX_BOND;
  localparam int RAB = $clog2(RD);
  localparam int CW  = 2 * VALUE_BITS;
  localparam int RW  = CW * MAX_BOND;
  localparam int SCW = $clog2(MAX_SITES + 1);

  typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_MAC, ST_DRAIN, ST_SHIFT, ST_OUT} st_t;

  st_t                state_r;
  logic [RAB:0]       clr_r;
  logic [CFG_BITS-1:0] sc_r;
  logic [SCW-1:0]     nsites_r;
  logic [SCW-1:0]     q_r;
  logic [BB:0]        k_r;
  logic [BASIS_WIDTH-1:0] basis_r;
  logic               out_valid_r;
  logic signed [VALUE_BITS-1:0] amp_re_r, amp_im_r;

  // vector is kept in a shift line, element 0 at the head
  logic signed [VALUE_BITS-1:0] vec_re_r [MAX_BOND];
  logic signed [VALUE_BITS-1:0] vec_im_r [MAX_BOND];

  // row-wide store: one address holds all columns of one matrix row
  logic           ram_we;
  logic [RAB-1:0] ram_wa, ram_ra;
  logic [RW-1:0]  ram_wd, ram_rd, row_cur;
  logic           row_we_r;
  logic [RAB-1:0] row_wa_r;
  logic [RW-1:0]  row_wd_r;

  logic           wr_pend_r;
  logic [BB-1:0]  wr_col_r;
  logic [CW-1:0]  wr_val_r;
  logic           wr_ok;

  logic           mac_en, cell_clear, cell_load, cell_shift;
  logic signed [VALUE_BITS-1:0] cre [MAX_BOND];
  logic signed [VALUE_BITS-1:0] cim [MAX_BOND];
  logic signed [VALUE_BITS-1:0] mac_v_re_r, mac_v_im_r;
  logic           mac_v_r;

  assign in_ready  = (state_r == ST_IDLE) && !wr_pend_r && !row_we_r;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_amp_re = amp_re_r;
  assign out_amp_im = amp_im_r;

  assign wr_ok = (32'(in_site) < MAX_SITES) && (32'(in_row) < MAX_BOND)
                 && (32'(in_column) < MAX_BOND);

  function automatic logic [RAB-1:0] row_addr(input logic [SB-1:0] s, input logic p,
                                               input logic [BB-1:0] r);
    return RAB'((32'(s) * 2 + 32'(p)) * MAX_BOND + 32'(r));
  endfunction

  // read address: write fetch, or row k of the current site matrix
  always_comb begin
    logic p;
    p = (32'(q_r) < BASIS_WIDTH) ? basis_r[q_r[$clog2(BASIS_WIDTH)-1:0]] : 1'b0;
    if (state_r == ST_IDLE && in_valid && in_ready) begin
      ram_ra = row_addr(SB'(in_site), in_phys_bit, BB'(in_row));
    end else begin
      ram_ra = row_addr(SB'(q_r), p, k_r[BB-1:0]);
    end
  end

  // merge of a pending entry into its fetched row
  always_comb begin
    row_cur = ram_rd;
    row_cur[wr_col_r*CW +: CW] = wr_val_r;
  end

  always_comb begin
    if (state_r == ST_CLEAR) begin
      ram_we = 1'b1;
      ram_wa = clr_r[RAB-1:0];
      ram_wd = '0;
    end else begin
      ram_we = row_we_r;
      ram_wa = row_wa_r;
      ram_wd = row_wd_r;
    end
  end

  mae_ram #(.WIDTH(RW), .DEPTH(RD)) u_store (
    .clk(clk), .wr_en(ram_we), .wr_addr(ram_wa), .wr_data(ram_wd),
    .rd_addr(ram_ra), .rd_data(ram_rd)
  );

  assign cell_clear = (state_r == ST_IDLE) || (state_r == ST_SHIFT);
  assign mac_en     = mac_v_r;
  assign cell_load  = (state_r == ST_DRAIN) && (k_r == '0);
  assign cell_shift = (state_r == ST_SHIFT);

  // row of cells, one per column, shifting the result toward cell 0
  for (genvar c = 0; c < MAX_BOND; c++) begin : g_cell
    logic signed [VALUE_BITS-1:0] sin_re, sin_im;
    if (c == MAX_BOND - 1) begin : g_end
      assign sin_re = '0;
      assign sin_im = '0;
    end else begin : g_mid
      assign sin_re = cre[c+1];
      assign sin_im = cim[c+1];
    end
    mae_cell #(.VALUE_BITS(VALUE_BITS), .FRAC_BITS(FRAC_BITS)) u_cell (
      .clk(clk), .clear(cell_clear), .mac_en(mac_en),
      .v_re(mac_v_re_r), .v_im(mac_v_im_r),
      .t_re(ram_rd[c*CW +: VALUE_BITS]), .t_im(ram_rd[c*CW+VALUE_BITS +: VALUE_BITS]),
      .load(cell_load), .shift_in_re(sin_re), .shift_in_im(sin_im),
      .shift_en(cell_shift), .out_re(cre[c]), .out_im(cim[c])
    );
  end

  // sequencer: clear pass, writes, per-site mac, drain and shift back
  always_ff @(posedge clk) begin
    row_we_r <= 1'b0;
    row_wd_r <= row_cur;
    mac_v_r  <= 1'b0;
    mac_v_re_r <= vec_re_r[0];
    mac_v_im_r <= vec_im_r[0];
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      sc_r        <= CFG_BITS'(1);
      out_valid_r <= 1'b0;
      wr_pend_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) sc_r <= cfg_site_count;
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (wr_pend_r) begin
        row_we_r  <= 1'b1;
        wr_pend_r <= 1'b0;
      end
      unique case (state_r)
        ST_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (32'(clr_r) == RD - 1) state_r <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            if (in_kind == KIND_WRITE) begin
              wr_pend_r <= wr_ok;
              row_wa_r  <= ram_ra;
              wr_col_r  <= BB'(in_column);
              wr_val_r  <= {in_entry_im, in_entry_re};
            end else begin
              basis_r  <= in_basis_bits;
              nsites_r <= (32'(sc_r) > MAX_SITES) ? SCW'(MAX_SITES) : SCW'(sc_r);
              q_r      <= '0;
              k_r      <= '0;
              for (int i = 0; i < MAX_BOND; i++) begin
                vec_re_r[i] <= '0;
                vec_im_r[i] <= '0;
              end
              vec_re_r[0] <= VALUE_BITS'(1) <<< FRAC_BITS;
              if (32'(sc_r) == 0) state_r <= ST_OUT;
              else state_r <= ST_MAC;
            end
          end
        end
        ST_MAC: begin
          // row k issued now; data and vector element arrive next cycle
          mac_v_r <= 1'b1;
          for (int i = 0; i < MAX_BOND - 1; i++) begin
            vec_re_r[i] <= vec_re_r[i+1];
            vec_im_r[i] <= vec_im_r[i+1];
          end
          k_r <= k_r + 1'b1;
          if (32'(k_r) == MAX_BOND - 1) begin
            k_r     <= (BB+1)'(3);
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          k_r <= k_r - 1'b1;
          if (k_r == '0) begin
            k_r     <= '0;
            state_r <= ST_SHIFT;
          end
        end
        ST_SHIFT: begin
          vec_re_r[MAX_BOND-1] <= cre[0];
          vec_im_r[MAX_BOND-1] <= cim[0];
          for (int i = 0; i < MAX_BOND - 1; i++) begin
            vec_re_r[i] <= vec_re_r[i+1];
            vec_im_r[i] <= vec_im_r[i+1];
          end
          k_r <= k_r + 1'b1;
          if (32'(k_r) == MAX_BOND - 1) begin
            k_r <= '0;
            q_r <= q_r + 1'b1;
            if (q_r + 1'b1 == nsites_r) state_r <= ST_OUT;
            else state_r <= ST_MAC;
          end
        end
        ST_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            amp_re_r    <= vec_re_r[0];
            amp_im_r    <= vec_im_r[0];
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: bench/testbench.sv
// self-checking bench for mps_amplitude_evaluator: tensor writes, amplitude queries
// depends on mae_pkg and the mps_amplitude_evaluator rtl
`timescale 1ns / 1ps

module testbench;
  import mae_pkg::*;

  localparam int MAX_SITES  = 16;
  localparam int MAX_BOND   = 8;
  localparam int VALUE_BITS = 18;
  localparam int FRAC_BITS  = VALUE_BITS - 3;
  localparam int DEPTH      = MAX_SITES * 2 * MAX_BOND * MAX_BOND;
  localparam int RANDOM_ITEMS = 1150;
  localparam int QUERY_CYCLES = 16 * (2 * MAX_BOND + 4) + 8;

  typedef logic signed [VALUE_BITS-1:0] val_t;
  typedef struct packed {
    val_t re;
    val_t im;
  } amp_t;
  typedef struct packed {
    kind_t                  kind;
    logic [SITE_BITS-1:0]   site;
    logic                   phys;
    logic [BOND_BITS-1:0]   row;
    logic [BOND_BITS-1:0]   column;
    val_t                   ere;
    val_t                   eim;
    logic [BASIS_WIDTH-1:0] basis;
  } item_t;

  logic clk, rst_n;
  logic in_valid, in_ready, in_kind, in_phys_bit;
  logic [SITE_BITS-1:0] in_site;
  logic [BOND_BITS-1:0] in_row, in_column;
  val_t in_entry_re, in_entry_im, out_amp_re, out_amp_im;
  logic [BASIS_WIDTH-1:0] in_basis_bits;
  logic out_valid, out_ready, cfg_valid, cfg_ready;
  logic [CFG_BITS-1:0] cfg_site_count;

  mps_amplitude_evaluator #(
    .MAX_SITES(MAX_SITES), .MAX_BOND(MAX_BOND), .VALUE_BITS(VALUE_BITS)
  ) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_kind(in_kind),
    .in_site(in_site), .in_phys_bit(in_phys_bit), .in_row(in_row),
    .in_column(in_column), .in_entry_re(in_entry_re), .in_entry_im(in_entry_im),
    .in_basis_bits(in_basis_bits),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_amp_re(out_amp_re), .out_amp_im(out_amp_im),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_site_count(cfg_site_count)
  );

  // predictor state: tensor store and site count
  val_t tens_re [DEPTH];
  val_t tens_im [DEPTH];
  logic [CFG_BITS-1:0] sites_used;
  amp_t amp_queue [$];
  int errors;
  int send_idle_pct, recv_stall_pct;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #400ms;
    $display("testbench: done, errors");
    $finish;
  end

  function automatic val_t round_sat(longint acc);
    longint y, q;
    y = acc + (64'sd1 <<< (FRAC_BITS - 1));
    q = y >>> FRAC_BITS;
    if (q > (64'sd1 <<< (VALUE_BITS - 1)) - 1) q = (64'sd1 <<< (VALUE_BITS - 1)) - 1;
    if (q < -(64'sd1 <<< (VALUE_BITS - 1))) q = -(64'sd1 <<< (VALUE_BITS - 1));
    return val_t'(q);
  endfunction

  // contract e0 through the selected matrix of every site in use
  function automatic amp_t contract_amp(logic [BASIS_WIDTH-1:0] basis);
    longint vr [MAX_BOND], vi [MAX_BOND], nr [MAX_BOND], ni [MAX_BOND];
    longint ar, ai;
    int n, k;
    logic p;
    amp_t a;
    foreach (vr[c]) begin vr[c] = 0; vi[c] = 0; end
    vr[0] = 64'sd1 <<< FRAC_BITS;
    n = (sites_used > MAX_SITES) ? MAX_SITES : sites_used;
    for (int q = 0; q < n; q++) begin
      p = (q < BASIS_WIDTH) ? basis[q] : 1'b0;
      for (int c = 0; c < MAX_BOND; c++) begin
        ar = 0; ai = 0;
        for (int r = 0; r < MAX_BOND; r++) begin
          k = ((q * 2 + p) * MAX_BOND + r) * MAX_BOND + c;
          ar += vr[r] * tens_re[k] - vi[r] * tens_im[k];
          ai += vr[r] * tens_im[k] + vi[r] * tens_re[k];
        end
        nr[c] = round_sat(ar);
        ni[c] = round_sat(ai);
      end
      vr = nr; vi = ni;
    end
    a.re = val_t'(vr[0]);
    a.im = val_t'(vi[0]);
    return a;
  endfunction

  // apply one accepted item to the predictor
  task automatic predict_item(item_t it);
    int k;
    if (it.kind == KIND_WRITE) begin
      k = ((it.site * 2 + it.phys) * MAX_BOND + it.row) * MAX_BOND + it.column;
      tens_re[k] = it.ere;
      tens_im[k] = it.eim;
    end else begin
      amp_queue = {amp_queue, contract_amp(it.basis)};
    end
  endtask

  // valid stays high between back-to-back transfers, drops only while idling
  task automatic send_item(item_t it);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= it.kind;
    in_site       <= it.site;
    in_phys_bit   <= it.phys;
    in_row        <= it.row;
    in_column     <= it.column;
    in_entry_re   <= it.ere;
    in_entry_im   <= it.eim;
    in_basis_bits <= it.basis;
    do @(posedge clk); while (!in_ready);
    predict_item(it);
  endtask

  task automatic write_sites(logic [CFG_BITS-1:0] v);
    cfg_valid      <= 1'b1;
    cfg_site_count <= v;
    do @(posedge clk); while (!cfg_ready);
    sites_used = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (amp_queue.size() != 0 && guard < 2000000) begin
      @(posedge clk);
      guard++;
    end
    repeat (QUERY_CYCLES) @(posedge clk);
  endtask

  function automatic item_t wr(int s, int p, int r, int c, int re, int im);
    item_t it;
    it = '0;
    it.kind = KIND_WRITE; it.site = SITE_BITS'(s); it.phys = 1'(p);
    it.row = BOND_BITS'(r); it.column = BOND_BITS'(c);
    it.ere = val_t'(re); it.eim = val_t'(im);
    return it;
  endfunction

  function automatic item_t qry(int b);
    item_t it;
    it.kind = KIND_QUERY;
    it.site = SITE_BITS'($urandom); it.phys = 1'($urandom);
    it.row = BOND_BITS'($urandom); it.column = BOND_BITS'($urandom);
    it.ere = val_t'($urandom); it.eim = val_t'($urandom);
    it.basis = BASIS_WIDTH'(b);
    return it;
  endfunction

  // random item: entries, most in the live bond block, plus queries
  function automatic item_t rand_item();
    item_t it;
    int mode;
    mode = $urandom_range(99);
    if (mode < 35) return qry($urandom);
    it = wr($urandom_range(15), $urandom_range(1), $urandom_range(7),
            $urandom_range(7), 0, 0);
    if (mode < 80) begin
      it.row = BOND_BITS'($urandom_range(2));
      it.column = BOND_BITS'($urandom_range(2));
      it.ere = $signed(18'($urandom_range(65535))) - 18'sd32768;
      it.eim = $signed(18'($urandom_range(32767))) - 18'sd16384;
    end else begin
      it.ere = val_t'($urandom);
      it.eim = val_t'($urandom);
    end
    return it;
  endfunction

  // result checker
  always @(posedge clk) begin
    amp_t want;
    if (rst_n && out_valid && out_ready) begin
      if (amp_queue.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected amplitude %0d %0d", out_amp_re, out_amp_im);
      end else begin
        want = amp_queue.pop_front();
        if (want.re !== out_amp_re || want.im !== out_amp_im) begin
          errors++;
          if (errors <= 10)
            $display("amplitude mismatch: expected %0d %0d, got %0d %0d",
                     want.re, want.im, out_amp_re, out_amp_im);
        end
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    out_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  // directed rows; fixed amplitudes where obvious, else predictor
  typedef struct {
    item_t it;
    bit    fixed;
    amp_t  amp;
  } row_t;

  initial begin
    row_t rows [$];
    row_t rw;
    amp_t fix_amp;
    int phase;
    errors = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    rst_n = 1'b0; in_valid = 1'b0; cfg_valid = 1'b0; out_ready = 1'b0;
    in_kind = 1'b0; in_site = '0; in_phys_bit = 1'b0; in_row = '0; in_column = '0;
    in_entry_re = '0; in_entry_im = '0; in_basis_bits = '0; cfg_site_count = 5'd1;
    foreach (tens_re[i]) begin tens_re[i] = '0; tens_im[i] = '0; end
    sites_used = 5'd1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // after reset the store is zero
    rw.it = qry(16'hffff); rw.fixed = 1; rw.amp = '0; rows = {rows, rw};
    rw.fixed = 0;
    rw.it = wr(0, 0, 0, 0, 32768, 0);            rows = {rows, rw};
    rw.it = wr(0, 1, 0, 0, 131071, -131072);     rows = {rows, rw};
    rw.it = wr(0, 1, 7, 7, -131072, 131071);     rows = {rows, rw};
    rw.it = wr(15, 1, 7, 7, 12345, -54321);      rows = {rows, rw};
    rw.fixed = 1;
    rw.it = qry(0); rw.amp.re = val_t'(32768); rw.amp.im = '0; rows = {rows, rw};
    rw.it = qry(1); rw.amp.re = val_t'(131071); rw.amp.im = val_t'(-131072);
    rows = {rows, rw};
    rw.fixed = 0;
    foreach (rows[i]) begin
      send_item(rows[i].it);
      if (rows[i].fixed && rows[i].it.kind == KIND_QUERY) begin
        void'(amp_queue.pop_back());
        amp_queue = {amp_queue, rows[i].amp};
      end
    end
    drain();

    // zero sites gives one
    write_sites(5'd0);
    send_item(qry(16'h1234));
    void'(amp_queue.pop_back());
    fix_amp.re = val_t'(32768);
    fix_amp.im = '0;
    amp_queue = {amp_queue, fix_amp};
    drain();
    // saturation across two sites, then above-maximum and maximum site counts
    write_sites(5'd2);
    send_item(wr(1, 1, 0, 0, 131071, 131071));
    send_item(qry(16'h0003));
    send_item(qry(16'h0002));
    drain();
    write_sites(5'd31);
    send_item(qry(16'hffff));
    send_item(qry(16'h0000));
    drain();
    write_sites(5'd16);
    send_item(qry(16'h8001));
    drain();

    // random phases at differing site counts and idling patterns
    for (phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      write_sites(phase == 7 ? 5'd16 : 5'($urandom_range(1, 20)));
      repeat (RANDOM_ITEMS / 8) send_item(rand_item());
      drain();
    end

    if (errors == 0 && amp_queue.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end
endmodule

// File: mps_amplitude_evaluator.f
hdl/mae_pkg.sv
hdl/mae_ram.sv
hdl/mae_cell.sv
hdl/mps_amplitude_evaluator.sv
bench/testbench.sv
